### src/qsbe_pkg.sv
package qsbe_pkg;

   // Fixed-point format
   localparam int FRAC_BITS = 16;
   localparam int ONE_Q     = 1 << FRAC_BITS;
   localparam int HALF_Q    = ONE_Q >> 1;

   // Saturation limits of the result fields
   localparam int VAL_LIM   = 131072;
   localparam int GRAD_LIM  = 262144;

   // Field widths
   localparam int AXES      = 3;
   localparam int DIM_W     = 2;
   localparam int COORD_W   = 17;
   localparam int JAC_W     = 32;
   localparam int INDEX_W   = 4;
   localparam int VALUE_W   = 19;
   localparam int GRAD_W    = 20;
   localparam int TGRAD_W   = 32;

   // Stream data widths, padded to whole bytes
   localparam int REQ_FIELDS_W = AXES * COORD_W + AXES * AXES * JAC_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = INDEX_W + VALUE_W + AXES * GRAD_W + AXES * TGRAD_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;

   typedef logic [AXES-1:0][COORD_W-1:0]           coord_vec_type;
   // [row][col]
   typedef logic [AXES-1:0][AXES-1:0][JAC_W-1:0]   jac_mat_type;
   typedef logic [AXES-1:0][GRAD_W-1:0]            grad_vec_type;
   typedef logic [AXES-1:0][TGRAD_W-1:0]           tgrad_vec_type;

   // Number of basis functions for an element dimension
   function automatic logic [INDEX_W-1:0] basis_count(input logic [DIM_W-1:0] dim);
      logic [INDEX_W-1:0] cnt;
      unique case (dim)
         2'd0: cnt = 4'd1;
         2'd1: cnt = 4'd3;
         2'd2: cnt = 4'd6;
         default: cnt = 4'd10;
      endcase
      return cnt;
   endfunction

endpackage

### src/qsbe_basis.sv
module qsbe_basis (
   input  qsbe_pkg::coord_vec_type                coord,
   input  logic [qsbe_pkg::DIM_W-1:0]             dim,
   input  logic [qsbe_pkg::INDEX_W-1:0]           index,
   output logic signed [qsbe_pkg::VALUE_W-1:0]    value,
   output qsbe_pkg::grad_vec_type                 grad
);
   import qsbe_pkg::*;

   localparam int BC_W    = 20;
   localparam int PROD_W  = 2 * BC_W;
   localparam int VACC_W  = PROD_W + 2;
   localparam int GSUM_W  = BC_W + 4;
   localparam int SUM_W   = COORD_W + 2;

   typedef enum logic [1:0] {SLOPE_ZERO, SLOPE_POS, SLOPE_NEG} slope_type;

   typedef struct packed {
      logic [1:0] a;
      logic [1:0] b;
   } pair_type;

   // Barycentric pair of each basis function; a == b marks a vertex function
   function automatic pair_type basis_pair(input logic [DIM_W-1:0] d,
                                           input logic [INDEX_W-1:0] k);
      pair_type p;
      p = '{a: 2'd0, b: 2'd0};
      unique case (d)
         2'd0: p = '{a: 2'd0, b: 2'd0};
         2'd1: begin
            case (k)
               4'd0: p = '{a: 2'd0, b: 2'd0};
               4'd1: p = '{a: 2'd1, b: 2'd1};
               default: p = '{a: 2'd0, b: 2'd1};
            endcase
         end
         2'd2: begin
            case (k)
               4'd0: p = '{a: 2'd0, b: 2'd0};
               4'd1: p = '{a: 2'd1, b: 2'd1};
               4'd2: p = '{a: 2'd2, b: 2'd2};
               4'd3: p = '{a: 2'd0, b: 2'd1};
               4'd4: p = '{a: 2'd0, b: 2'd2};
               default: p = '{a: 2'd1, b: 2'd2};
            endcase
         end
         default: begin
            case (k)
               4'd0: p = '{a: 2'd0, b: 2'd0};
               4'd1: p = '{a: 2'd1, b: 2'd1};
               4'd2: p = '{a: 2'd2, b: 2'd2};
               4'd3: p = '{a: 2'd3, b: 2'd3};
               4'd4: p = '{a: 2'd0, b: 2'd1};
               4'd5: p = '{a: 2'd0, b: 2'd2};
               4'd6: p = '{a: 2'd0, b: 2'd3};
               4'd7: p = '{a: 2'd1, b: 2'd2};
               4'd8: p = '{a: 2'd1, b: 2'd3};
               default: p = '{a: 2'd2, b: 2'd3};
            endcase
         end
      endcase
      return p;
   endfunction

   // Derivative of barycentric k along an axis
   function automatic slope_type bary_slope(input logic [1:0] k, input logic [1:0] axis);
      slope_type s;
      if (k == 2'd0) begin
         s = SLOPE_NEG;
      end else if (k == 2'(axis + 2'd1)) begin
         s = SLOPE_POS;
      end else begin
         s = SLOPE_ZERO;
      end
      return s;
   endfunction

   function automatic logic signed [GSUM_W-1:0] apply_slope(
      input logic signed [GSUM_W-1:0] v, input slope_type s);
      logic signed [GSUM_W-1:0] r;
      case (s)
         SLOPE_POS: r = v;
         SLOPE_NEG: r = -v;
         default:   r = '0;
      endcase
      return r;
   endfunction

   logic [AXES-1:0][COORD_W-1:0]   coord_used;
   logic [SUM_W-1:0]               coord_sum;
   logic signed [BC_W-1:0]         bc [4];
   pair_type                       pair;
   logic                           vertex;
   logic signed [BC_W-1:0]         bc_a;
   logic signed [BC_W-1:0]         bc_b;
   logic signed [BC_W-1:0]         mul_b;
   logic signed [PROD_W-1:0]       prod;
   logic signed [VACC_W-1:0]       vacc;
   logic signed [VACC_W-1:0]       vrnd;
   logic signed [GSUM_W-1:0]       gsum;

   // Barycentric coordinates, unused axes forced to zero
   always_comb begin
      coord_sum = '0;
      for (int i = 0; i < AXES; i++) begin
         coord_used[i] = (i < int'(dim)) ? coord[i] : '0;
         coord_sum     = coord_sum + SUM_W'(coord_used[i]);
      end
      bc[0] = BC_W'(ONE_Q) - $signed(BC_W'(coord_sum));
      for (int i = 0; i < AXES; i++) begin
         bc[i+1] = $signed(BC_W'(coord_used[i]));
      end
   end

   // Value: 2a(a - 1/2) or 4ab, rounded half up, saturated
   always_comb begin
      pair   = basis_pair(dim, index);
      vertex = (pair.a == pair.b);
      bc_a   = bc[pair.a];
      bc_b   = bc[pair.b];
      mul_b  = vertex ? BC_W'(bc_a - BC_W'(HALF_Q)) : bc_b;
      prod   = PROD_W'(bc_a) * PROD_W'(mul_b);
      vacc   = vertex ? (VACC_W'(prod) <<< 1) : (VACC_W'(prod) <<< 2);
      vrnd   = (vacc + VACC_W'(HALF_Q)) >>> FRAC_BITS;
      if (vrnd > VACC_W'(VAL_LIM)) begin
         value = VALUE_W'(VAL_LIM);
      end else if (vrnd < VACC_W'(-VAL_LIM)) begin
         value = VALUE_W'(-VAL_LIM);
      end else begin
         value = VALUE_W'(vrnd);
      end
   end

   // Canonical gradient, exact then saturated; zero beyond the dimension
   always_comb begin
      gsum = '0;
      for (int ax = 0; ax < AXES; ax++) begin
         if (vertex) begin
            gsum = apply_slope((GSUM_W'(bc_a) <<< 2) - GSUM_W'(ONE_Q),
                               bary_slope(pair.a, 2'(ax)));
         end else begin
            gsum = (apply_slope(GSUM_W'(bc_a), bary_slope(pair.b, 2'(ax)))
                  + apply_slope(GSUM_W'(bc_b), bary_slope(pair.a, 2'(ax)))) <<< 2;
         end
         if (ax >= int'(dim)) begin
            grad[ax] = '0;
         end else if (gsum > GSUM_W'(GRAD_LIM)) begin
            grad[ax] = GRAD_W'(GRAD_LIM);
         end else if (gsum < GSUM_W'(-GRAD_LIM)) begin
            grad[ax] = GRAD_W'(-GRAD_LIM);
         end else begin
            grad[ax] = GRAD_W'(gsum);
         end
      end
   end

endmodule

### src/qsbe_xform.sv
module qsbe_xform (
   input  qsbe_pkg::grad_vec_type        grad,
   input  qsbe_pkg::jac_mat_type         jac,
   input  logic [qsbe_pkg::DIM_W-1:0]    dim,
   output qsbe_pkg::tgrad_vec_type       tgrad
);
   import qsbe_pkg::*;

   localparam int PROD_W = GRAD_W + JAC_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam logic signed [ACC_W-1:0] T_MAX = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] T_MIN = ~T_MAX;

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  rnd;

   // Row vector times matrix; rows past the dimension carry zero gradient
   always_comb begin
      prod = '0;
      acc  = '0;
      rnd  = '0;
      for (int col = 0; col < AXES; col++) begin
         acc = '0;
         for (int row = 0; row < AXES; row++) begin
            prod = PROD_W'($signed(grad[row])) * PROD_W'($signed(jac[row][col]));
            acc  = acc + ACC_W'(prod);
         end
         rnd = (acc + ACC_W'(HALF_Q)) >>> FRAC_BITS;
         if (col >= int'(dim)) begin
            tgrad[col] = '0;
         end else if (rnd > T_MAX) begin
            tgrad[col] = TGRAD_W'(T_MAX);
         end else if (rnd < T_MIN) begin
            tgrad[col] = TGRAD_W'(T_MIN);
         end else begin
            tgrad[col] = TGRAD_W'(rnd);
         end
      end
   end

endmodule

### src/quadratic_simplex_basis_eval.sv
// Quadratic Lagrange basis evaluator on the canonical simplex (dimension 0..3).
// req_*: one transfer per point: canonical coordinates plus a 3x3 inverse
//   Jacobian. rsp_*: one transfer per basis function, in local index order,
//   rsp_tlast on the final one (1, 3, 6 or 10 transfers for dimension 0..3).
// csr_*: writes the element dimension; always ready. Write it only while the
//   block is idle; the dimension is captured with each point.
// Path: a point's results pass the item register, the basis stage and the
//   output register in that order.
// Throughput: one result per cycle unless rsp_tready stalls the output; the
//   single basis/transform datapath serves every basis function in turn. The
//   next point is taken in the cycle its predecessor's last basis function
//   enters the pipeline.
// Reset: the dimension returns to 3 and all stages empty.
// Stall: when rsp_tready is low the output register holds its result and
//   the pipeline stops behind it; req_tready drops once the item register
//   cannot release its point.
module quadratic_simplex_basis_eval (
   input  logic                                clock,
   input  logic                                reset,
   // coord_x, coord_y, coord_z, jac_00, jac_01, jac_02, jac_10, jac_11,
   // jac_12, jac_20, jac_21, jac_22, zero pad
   input  logic [qsbe_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // basis_index, basis_value, grad_x, grad_y, grad_z, tgrad_x, tgrad_y,
   // tgrad_z, zero pad
   output logic [qsbe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [qsbe_pkg::DIM_W-1:0]          csr_data,
   input  logic                                csr_valid,
   output logic                                csr_ready
);
   import qsbe_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0]         index;
      logic signed [VALUE_W-1:0]  value;
      grad_vec_type               grad;
      logic                       last;
      jac_mat_type                jac;
      logic [DIM_W-1:0]           dim;
   } stage_type;

   // Dimension register
   logic [DIM_W-1:0]      dim_ff, dim_in;

   // Item register and basis counter
   logic                  item_valid_ff, item_valid_in;
   logic [DIM_W-1:0]      item_dim_ff, item_dim_in;
   coord_vec_type         coord_ff, coord_in;
   jac_mat_type           jac_ff, jac_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;

   // Basis stage
   logic                  s1_valid_ff, s1_valid_in;
   stage_type             s1_ff, s1_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   coord_vec_type         req_coord;
   jac_mat_type           req_jac;
   logic                  req_xfer;
   logic                  out_adv;
   logic                  s1_adv;
   logic                  gen_fire;
   logic                  gen_last;
   logic signed [VALUE_W-1:0] basis_value;
   grad_vec_type          basis_grad;
   tgrad_vec_type         tgrad;

   // Unpack the request
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         req_coord[k] = req_tdata[k*COORD_W +: COORD_W];
      end
      for (int r = 0; r < AXES; r++) begin
         for (int c = 0; c < AXES; c++) begin
            req_jac[r][c] = req_tdata[AXES*COORD_W + (r*AXES + c)*JAC_W +: JAC_W];
         end
      end
   end

   // Pipeline flow control
   always_comb begin
      out_adv    = !rsp_valid_ff || rsp_tready;
      s1_adv     = !s1_valid_ff || out_adv;
      gen_last   = (idx_ff == INDEX_W'(basis_count(item_dim_ff) - 4'd1));
      gen_fire   = item_valid_ff && s1_adv;
      req_tready = !item_valid_ff || (s1_adv && gen_last);
      req_xfer   = req_tvalid && req_tready;
   end

   assign csr_ready = 1'b1;

   always_comb begin
      dim_in = (csr_valid && csr_ready) ? csr_data : dim_ff;
   end

   // Item register: load on transfer, step through the basis functions
   always_comb begin
      item_valid_in = item_valid_ff;
      item_dim_in   = item_dim_ff;
      coord_in      = coord_ff;
      jac_in        = jac_ff;
      idx_in        = idx_ff;
      if (req_xfer) begin
         item_valid_in = 1'b1;
         item_dim_in   = dim_ff;
         coord_in      = req_coord;
         jac_in        = req_jac;
         idx_in        = '0;
      end else if (gen_fire) begin
         if (gen_last) begin
            item_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   qsbe_basis u_basis (
      .coord (coord_ff),
      .dim   (item_dim_ff),
      .index (idx_ff),
      .value (basis_value),
      .grad  (basis_grad)
   );

   // Basis stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (s1_adv) begin
         s1_valid_in = item_valid_ff;
         s1_in.index = idx_ff;
         s1_in.value = basis_value;
         s1_in.grad  = basis_grad;
         s1_in.last  = gen_last;
         s1_in.jac   = jac_ff;
         s1_in.dim   = item_dim_ff;
      end
   end

   qsbe_xform u_xform (
      .grad  (s1_ff.grad),
      .jac   (s1_ff.jac),
      .dim   (s1_ff.dim),
      .tgrad (tgrad)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_adv) begin
         rsp_valid_in = s1_valid_ff;
         rsp_last_in  = s1_ff.last;
         rsp_data_in  = RSP_DATA_W'({tgrad, s1_ff.grad, s1_ff.value, s1_ff.index});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff        <= DIM_RESET;
         item_valid_ff <= 1'b0;
         idx_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dim_ff        <= dim_in;
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_dim_ff <= item_dim_in;
      coord_ff    <= coord_in;
      jac_ff      <= jac_in;
      s1_ff       <= s1_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Basis counter never runs past the point's function count
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff |-> (idx_ff < basis_count(item_dim_ff)))
      else $error("basis index past function count");

   // A non-final result in the basis stage means its point is still held
   a_s1_item: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_ff.last) |-> item_valid_ff)
      else $error("point released before its last basis function");

   // A non-final result at the output always has its successor queued
   a_rsp_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> s1_valid_ff)
      else $error("gap inside a point's result run");

   // Third gradient axis is unused below dimension 3
   a_grad_z: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_ff.dim != DIM_RESET)) |-> (s1_ff.grad[2] == '0))
      else $error("gradient on unused axis");

endmodule

### sim/tb_quadratic_simplex_basis_eval.sv
module tb_quadratic_simplex_basis_eval;
   import qsbe_pkg::*;

   // Result field offsets inside rsp_tdata
   localparam int OFF_VAL   = INDEX_W;
   localparam int OFF_GRAD  = OFF_VAL + VALUE_W;
   localparam int OFF_TGRAD = OFF_GRAD + AXES * GRAD_W;
   localparam longint TG_MIN = -64'sd2147483648;
   localparam longint TG_MAX = 64'sd2147483647;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      logic                  last;
      logic [RSP_DATA_W-1:0] data;
   } basis_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DIM_W-1:0]      csr_data = '0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;

   // Testbench copy of the dimension register
   logic [DIM_W-1:0]      dim_shadow = DIM_RESET;

   logic [REQ_DATA_W-1:0] pending_points[$];
   basis_result_type      expected_basis[$];
   logic [REQ_DATA_W-1:0] cur_point = '0;
   int                    send_gap = 0;
   int                    rx_gap = 0;
   int                    hold_left = 0;
   int                    mismatch_cnt = 0;
   bit                    quiet_mode = 1'b0;
   bit                    stall_armed = 1'b0;
   bit                    stall_used = 1'b0;

   quadratic_simplex_basis_eval uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Gap lengths: mostly none or short, a few long; none in quiet stretches
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Round to nearest at FRAC_BITS, ties toward plus infinity
   function automatic longint round_q(input longint x);
      return (x + HALF_Q) >>> FRAC_BITS;
   endfunction

   function automatic longint clamp(input longint x, input longint lo, input longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   // d(lambda_k)/d(axis i); lambda_0 = 1 - sum of coordinates
   function automatic longint lambda_slope(input int k, input int i);
      if (k == 0) return -1;
      return (k - 1 == i) ? 1 : 0;
   endfunction

   // Compute every basis result of one point and queue them in index order
   function automatic void predict_basis(input logic [REQ_DATA_W-1:0] pt,
                                         input logic [DIM_W-1:0] dm);
      longint           bc[4];
      longint           jm[3][3];
      longint           g[3];
      longint           t[3];
      longint           v, gv, acc, sum, cv, da, tmp;
      int               d, cnt, k, i, j, a, b, e;
      basis_result_type r;
      d = int'(dm);
      sum = 0;
      for (i = 0; i < AXES; i++) begin
         cv = longint'(pt[i*COORD_W +: COORD_W]);
         if (i >= d) cv = 0;
         bc[i+1] = cv;
         sum += cv;
      end
      bc[0] = ONE_Q - sum;
      for (i = 0; i < AXES; i++)
         for (j = 0; j < AXES; j++)
            jm[i][j] = longint'($signed(pt[AXES*COORD_W + (i*AXES+j)*JAC_W +: JAC_W]));
      cnt = (d + 1) * (d + 2) / 2;
      for (k = 0; k < cnt; k++) begin
         // vertices first, then edges (a,b) with a < b in lexical order
         if (k <= d) begin
            a = k;
            b = k;
         end else begin
            e = k - d - 1;
            a = 0;
            b = 1;
            repeat (e) begin
               b++;
               if (b > d) begin
                  a++;
                  b = a + 1;
               end
            end
         end
         if (a == b) v = 2 * bc[a] * (bc[a] - HALF_Q);
         else v = 4 * bc[a] * bc[b];
         v = clamp(round_q(v), -VAL_LIM, VAL_LIM);
         for (i = 0; i < AXES; i++) begin
            g[i] = 0;
            t[i] = 0;
         end
         for (i = 0; i < d; i++) begin
            da = lambda_slope(a, i);
            if (a == b) gv = (4 * bc[a] - ONE_Q) * da;
            else gv = 4 * (bc[a] * lambda_slope(b, i) + bc[b] * da);
            g[i] = clamp(gv, -GRAD_LIM, GRAD_LIM);
         end
         // saturated canonical gradient as row vector times the Jacobian
         for (j = 0; j < d; j++) begin
            acc = 0;
            for (i = 0; i < d; i++) acc += g[i] * jm[i][j];
            t[j] = clamp(round_q(acc), TG_MIN, TG_MAX);
         end
         r = '0;
         r.data[INDEX_W-1:0] = k[INDEX_W-1:0];
         r.data[OFF_VAL +: VALUE_W] = v[VALUE_W-1:0];
         for (i = 0; i < AXES; i++) begin
            tmp = g[i];
            r.data[OFF_GRAD + i*GRAD_W +: GRAD_W] = tmp[GRAD_W-1:0];
            tmp = t[i];
            r.data[OFF_TGRAD + i*TGRAD_W +: TGRAD_W] = tmp[TGRAD_W-1:0];
         end
         r.last = (k + 1 == cnt);
         expected_basis.insert(expected_basis.size(), r);
      end
   endfunction

   function void check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         mismatch_cnt++;
      end
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_point(input coord_vec_type c,
                                                       input jac_mat_type m);
      logic [REQ_DATA_W-1:0] p;
      p = '0;
      p[REQ_FIELDS_W-1:0] = {m, c};
      return p;
   endfunction

   // Append one point to the driver's queue
   function automatic void add_point(input coord_vec_type c, input jac_mat_type m);
      pending_points.insert(pending_points.size(), pack_point(c, m));
   endfunction

   // Mostly points in or on the simplex, some anywhere in 17 bits
   function automatic coord_vec_type rand_coords();
      coord_vec_type c;
      int            r, i, left;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         left = ONE_Q;
         for (i = 0; i < AXES; i++) begin
            c[i] = COORD_W'($urandom_range(0, left));
            left -= int'(c[i]);
         end
      end else if (r < 85) begin
         for (i = 0; i < AXES; i++)
            case ($urandom_range(0, 2))
               0: c[i] = '0;
               1: c[i] = COORD_W'(ONE_Q);
               default: c[i] = COORD_W'(HALF_Q);
            endcase
      end else begin
         for (i = 0; i < AXES; i++)
            c[i] = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
      end
      return c;
   endfunction

   // Mostly moderate entries, some full range, some at the extremes
   function automatic jac_mat_type rand_jac();
      jac_mat_type m;
      int          r, i, j;
      for (i = 0; i < AXES; i++)
         for (j = 0; j < AXES; j++) begin
            r = $urandom_range(0, 99);
            if (r < 60) m[i][j] = $urandom_range(0, 1 << 19) - (1 << 18);
            else if (r < 85) m[i][j] = $urandom;
            else if (r < 92) m[i][j] = 32'h7FFF_FFFF;
            else m[i][j] = 32'h8000_0000;
         end
      return m;
   endfunction

   // Dimension register tracking
   always @(posedge clock) begin
      if (reset) begin
         dim_shadow <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         dim_shadow <= csr_data;
      end
   end

   // Point driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_basis(cur_point, dim_shadow);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_points.size() != 0) begin
               cur_point = pending_points.pop_front();
               req_tdata <= cur_point;
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // One long receiver hold-off so the pipeline backs up into req_tready
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (stall_armed && !stall_used) begin
         hold_left  <= HOLD_CYCLES;
         stall_used <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin
      basis_result_type exp_r;
      int               i;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_basis.size() == 0) begin
               $error("result transfer with no expected result, index %0d", rsp_tdata[3:0]);
               mismatch_cnt++;
            end else begin
               exp_r = expected_basis.pop_front();
               check_field("basis_index", 32'(exp_r.data[INDEX_W-1:0]),
                           32'(rsp_tdata[INDEX_W-1:0]));
               check_field("basis_value", 32'(exp_r.data[OFF_VAL +: VALUE_W]),
                           32'(rsp_tdata[OFF_VAL +: VALUE_W]));
               for (i = 0; i < AXES; i++) begin
                  check_field($sformatf("grad_%0d", i),
                              32'(exp_r.data[OFF_GRAD + i*GRAD_W +: GRAD_W]),
                              32'(rsp_tdata[OFF_GRAD + i*GRAD_W +: GRAD_W]));
                  check_field($sformatf("tgrad_%0d", i),
                              exp_r.data[OFF_TGRAD + i*TGRAD_W +: TGRAD_W],
                              rsp_tdata[OFF_TGRAD + i*TGRAD_W +: TGRAD_W]);
               end
               check_field("last", 32'(exp_r.last), 32'(rsp_tlast));
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rx_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   // Wait until every point went in and every result came out
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_points.size() != 0 || req_tvalid || expected_basis.size() != 0);
   endtask

   task automatic write_dimension(input logic [DIM_W-1:0] d);
      @(posedge clock);
      csr_data <= d;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stimulus sequence
   initial begin
      jac_mat_type   ident, jmax, jmin, jzero;
      coord_vec_type c;
      int            p, n, d;
      jzero = '0;
      ident = '0;
      for (n = 0; n < AXES; n++) ident[n][n] = ONE_Q;
      jmax = {(AXES*AXES){32'h7FFF_FFFF}};
      jmin = {(AXES*AXES){32'h8000_0000}};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset dimension (3), vertices, midpoints, outside points
      add_point({17'd0, 17'd0, 17'd0}, ident);
      add_point({17'd0, 17'd0, 17'd65536}, ident);
      add_point({17'd0, 17'd65536, 17'd0}, jmax);
      add_point({17'd65536, 17'd0, 17'd0}, jmin);
      add_point({17'd0, 17'd32768, 17'd32768}, rand_jac());
      add_point({17'd16384, 17'd16384, 17'd16384}, jzero);
      add_point({17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, jmax);
      add_point({17'd0, 17'd0, 17'h1FFFF}, jmin);
      wait_idle();

      // Dimension zero: single result of value one
      write_dimension(2'd0);
      add_point({17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, jmax);
      add_point({17'd0, 17'd0, 17'd0}, jmin);
      wait_idle();

      write_dimension(2'd1);
      add_point({17'd0, 17'd0, 17'd0}, ident);
      add_point({17'd5, 17'd9, 17'd65536}, jmax);
      add_point({17'd0, 17'd0, 17'd32768}, jmin);
      add_point({17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, jmax);
      wait_idle();

      write_dimension(2'd2);
      add_point({17'd0, 17'd65536, 17'd0}, ident);
      add_point({17'd77, 17'd0, 17'd65536}, jmin);
      add_point({17'd0, 17'd32768, 17'd32768}, jmax);
      add_point({17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, jmin);
      add_point({17'd0, 17'd21845, 17'd21845}, rand_jac());
      wait_idle();

      // Random phases across all dimensions
      for (p = 0; p < 8; p++) begin
         d = (p < 5) ? (p % 4) : $urandom_range(0, 3);
         if (p == 4) d = 3;
         write_dimension(d[DIM_W-1:0]);
         quiet_mode = (p % 3 == 1);
         for (n = 0; n < 18; n++) begin
            c = rand_coords();
            add_point(c, rand_jac());
         end
         if (p == 4) stall_armed = 1'b1;
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (mismatch_cnt == 0 && expected_basis.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(20 * 400000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### quadratic_simplex_basis_eval.f
src/qsbe_pkg.sv
src/qsbe_basis.sv
src/qsbe_xform.sv
src/quadratic_simplex_basis_eval.sv
sim/tb_quadratic_simplex_basis_eval.sv
